// ===== hw/rtl/pcrc_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// pcrc_pkg
// Shared types, register map and width helpers for the programmable CRC unit.
// ----------------------------------------------------------------------------
package pcrc_pkg;

	localparam int MAX_POLY_WIDTH = 32;

	// register map (index = paddr[4:2])
	localparam logic [2:0] REG_INIT_VALUE     = 3'd0;
	localparam logic [2:0] REG_POLYNOMIAL     = 3'd1;
	localparam logic [2:0] REG_POLY_WIDTH_SEL = 3'd2;
	localparam logic [2:0] REG_REVERSE_INPUT  = 3'd3;
	localparam logic [2:0] REG_REVERSE_OUTPUT = 3'd4;

	// polynomial width select
	localparam logic [1:0] WSEL_32 = 2'd0;
	localparam logic [1:0] WSEL_16 = 2'd1;
	localparam logic [1:0] WSEL_8  = 2'd2;
	localparam logic [1:0] WSEL_7  = 2'd3;

	// input reversal
	localparam logic [1:0] RIN_NONE = 2'd0;
	localparam logic [1:0] RIN_BYTE = 2'd1;
	localparam logic [1:0] RIN_HALF = 2'd2;
	localparam logic [1:0] RIN_WORD = 2'd3;

	// item function
	localparam logic FUNC_RESTART = 1'b0;
	localparam logic FUNC_FEED    = 1'b1;

	// access size
	localparam logic [1:0] ACC_BYTE = 2'd0;
	localparam logic [1:0] ACC_HALF = 2'd1;
	localparam logic [1:0] ACC_WORD = 2'd2;

	typedef struct packed {
		logic [31:0] init_value;
		logic [31:0] polynomial;
		logic [1:0]  poly_width_sel;
		logic [1:0]  reverse_input;
		logic        reverse_output;
	} pcrc_cfg_t;

	function automatic logic [5:0] poly_bits(input logic [1:0] sel);
		logic [5:0] n;
		case (sel)
			WSEL_32: n = 6'd32;
			WSEL_16: n = 6'd16;
			WSEL_8:  n = 6'd8;
			default: n = 6'd7;
		endcase
		if (n > 6'(MAX_POLY_WIDTH))
			n = 6'(MAX_POLY_WIDTH);
		return n;
	endfunction

	function automatic logic [31:0] poly_mask(input logic [5:0] n);
		logic [31:0] m;
		if (n >= 6'd32)
			m = 32'hFFFF_FFFF;
		else
			m = (32'd1 << n) - 32'd1;
		return m;
	endfunction

endpackage : pcrc_pkg
`default_nettype wire

// ===== hw/rtl/pcrc_regs.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// pcrc_regs
// APB register file: init value, polynomial, width select and reversal modes.
// ----------------------------------------------------------------------------
module pcrc_regs (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              psel,
	input  wire logic              penable,
	input  wire logic              pwrite,
	input  wire logic [4:0]        paddr,
	input  wire logic [31:0]       pwdata,
	output logic      [31:0]       prdata,
	output logic                   pready,
	output pcrc_pkg::pcrc_cfg_t    cfg
);
	import pcrc_pkg::*;

	pcrc_cfg_t  cfg_q;
	logic       wr_en;
	logic [2:0] idx;

	assign pready = 1'b1;
	assign idx    = paddr[4:2];
	assign wr_en  = psel && penable && pwrite && pready;
	assign cfg    = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.init_value     <= 32'hFFFF_FFFF;
			cfg_q.polynomial     <= 32'h04C1_1DB7;
			cfg_q.poly_width_sel <= WSEL_32;
			cfg_q.reverse_input  <= RIN_NONE;
			cfg_q.reverse_output <= 1'b0;
		end else if (wr_en) begin
			unique case (idx)
				REG_INIT_VALUE:     cfg_q.init_value     <= pwdata;
				REG_POLYNOMIAL:     cfg_q.polynomial     <= pwdata;
				REG_POLY_WIDTH_SEL: cfg_q.poly_width_sel <= pwdata[1:0];
				REG_REVERSE_INPUT:  cfg_q.reverse_input  <= pwdata[1:0];
				REG_REVERSE_OUTPUT: cfg_q.reverse_output <= pwdata[0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (idx)
			REG_INIT_VALUE:     prdata = cfg_q.init_value;
			REG_POLYNOMIAL:     prdata = cfg_q.polynomial;
			REG_POLY_WIDTH_SEL: prdata = {30'd0, cfg_q.poly_width_sel};
			REG_REVERSE_INPUT:  prdata = {30'd0, cfg_q.reverse_input};
			REG_REVERSE_OUTPUT: prdata = {31'd0, cfg_q.reverse_output};
			default:            prdata = 32'd0;
		endcase
	end

endmodule : pcrc_regs
`default_nettype wire

// ===== hw/rtl/pcrc_core.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// pcrc_core
// Byte-serial CRC engine: one shared 8-bit shift/XOR unit stepped by a small
// sequencer, plus an output register toward the result stream.
// ----------------------------------------------------------------------------
module pcrc_core (
	input  wire logic                   clk,
	input  wire logic                   arst_n,
	input  wire pcrc_pkg::pcrc_cfg_t    cfg,
	input  wire logic                   in_valid,
	output logic                        in_ready,
	input  wire logic                   in_func,
	input  wire logic [31:0]            in_data,
	input  wire logic [1:0]             in_size,
	output logic                        out_valid,
	input  wire logic                   out_ready,
	output logic      [31:0]            out_crc
);
	import pcrc_pkg::*;

	typedef enum logic [1:0] {S_IDLE, S_RUN, S_HOLD} state_t;

	state_t      state_q;
	logic [31:0] crc_q;
	logic [31:0] data_q;
	logic [1:0]  cnt_q;
	logic        out_valid_q;
	logic [31:0] out_crc_q;

	logic [5:0]  n_bits;
	logic [31:0] mask;
	logic [4:0]  fb_idx;
	logic [31:0] poly;
	logic [1:0]  size_eff;
	logic [1:0]  unit_eff;
	logic [31:0] din_masked;
	logic [31:0] din_rev;
	logic [31:0] din_aligned;
	logic [1:0]  nbytes_m1;
	logic [31:0] crc_step;
	logic [31:0] crc_rd;
	logic        accept;
	logic        out_free;

	function automatic logic [31:0] rev32(input logic [31:0] v);
		logic [31:0] r;
		for (int i = 0; i < 32; i++)
			r[i] = v[31-i];
		return r;
	endfunction

	// one byte through the shift register, MSB first
	function automatic logic [31:0] crc_byte(
		input logic [31:0] c_in,
		input logic [7:0]  b,
		input logic [31:0] p,
		input logic [31:0] m,
		input logic [4:0]  fbi
	);
		logic [31:0] c;
		logic        fb;
		c = c_in;
		for (int i = 7; i >= 0; i--) begin
			fb = c[fbi] ^ b[i];
			c  = (c << 1) & m;
			if (fb)
				c = c ^ p;
		end
		return c;
	endfunction

	assign n_bits = poly_bits(cfg.poly_width_sel);
	assign mask   = poly_mask(n_bits);
	assign fb_idx = 5'(n_bits - 6'd1);
	assign poly   = cfg.polynomial & mask;

	// access size three counts as a word
	assign size_eff = (in_size == ACC_BYTE) ? ACC_BYTE :
	                  (in_size == ACC_HALF) ? ACC_HALF : ACC_WORD;

	always_comb begin
		case (size_eff)
			ACC_BYTE: begin
				din_masked = in_data & 32'h0000_00FF;
				nbytes_m1  = 2'd0;
			end
			ACC_HALF: begin
				din_masked = in_data & 32'h0000_FFFF;
				nbytes_m1  = 2'd1;
			end
			default: begin
				din_masked = in_data;
				nbytes_m1  = 2'd3;
			end
		endcase
	end

	// reversal unit clamped to the access width; upper bits are zero already
	always_comb begin
		unit_eff = 2'(cfg.reverse_input - 2'd1);
		if (unit_eff > size_eff)
			unit_eff = size_eff;
		din_rev = din_masked;
		if (cfg.reverse_input != RIN_NONE) begin
			case (unit_eff)
				ACC_BYTE: begin
					for (int k = 0; k < 4; k++)
						din_rev[8*k +: 8] = 8'(rev32({24'd0, din_masked[8*k +: 8]}) >> 24);
				end
				ACC_HALF: begin
					for (int k = 0; k < 2; k++)
						din_rev[16*k +: 16] =
							16'(rev32({16'd0, din_masked[16*k +: 16]}) >> 16);
				end
				default: din_rev = rev32(din_masked);
			endcase
		end
	end

	// first byte to feed sits at [31:24]
	always_comb begin
		case (size_eff)
			ACC_BYTE: din_aligned = din_rev << 24;
			ACC_HALF: din_aligned = din_rev << 16;
			default:  din_aligned = din_rev;
		endcase
	end

	assign crc_step = crc_byte(crc_q, data_q[31:24], poly, mask, fb_idx);
	assign crc_rd   = cfg.reverse_output ? (rev32(crc_q & mask) >> (6'd32 - n_bits))
	                                     : (crc_q & mask);

	assign in_ready  = (state_q == S_IDLE);
	assign accept    = in_valid && in_ready;
	assign out_free  = !out_valid_q || out_ready;
	assign out_valid = out_valid_q;
	assign out_crc   = out_crc_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			crc_q       <= 32'hFFFF_FFFF;
			data_q      <= 32'd0;
			cnt_q       <= 2'd0;
			out_valid_q <= 1'b0;
			out_crc_q   <= 32'd0;
		end else begin
			if ((state_q == S_HOLD) && out_free)
				out_valid_q <= 1'b1;
			else if (out_ready)
				out_valid_q <= 1'b0;
			unique case (state_q)
				S_IDLE: begin
					if (accept) begin
						if (in_func == FUNC_RESTART) begin
							crc_q   <= cfg.init_value & mask;
							state_q <= S_HOLD;
						end else begin
							crc_q   <= crc_q & mask;
							data_q  <= din_aligned;
							cnt_q   <= nbytes_m1;
							state_q <= S_RUN;
						end
					end
				end
				S_RUN: begin
					crc_q  <= crc_step;
					data_q <= data_q << 8;
					cnt_q  <= cnt_q - 2'd1;
					if (cnt_q == 2'd0)
						state_q <= S_HOLD;
				end
				S_HOLD: begin
					if (out_free) begin
						out_crc_q <= crc_rd;
						state_q   <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

endmodule : pcrc_core
`default_nettype wire

// ===== hw/rtl/programmable_crc_unit.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// programmable_crc_unit
// CRC peripheral with programmable polynomial, width and bit reversal.
//
//   channel  dir  handshake            payload
//   s_*      in   s_tvalid/s_tready    s_tuser=func, s_tdata=data_word,size
//   m_*      out  m_tvalid/m_tready    m_tdata=crc_value
//   apb      in   psel/penable/pready  5 registers at 4*i
//
// A restart loads the init value and goes straight to the hold state; a
// feed first runs each byte of the access through the shared unit, which
// folds one byte per cycle. s_tready is low from accept until the result
// is in the output register; a stalled result holds off the next item
// only while the engine waits on it.
// Reset is asynchronous; the CRC register resets to all ones.
// ----------------------------------------------------------------------------
module programmable_crc_unit (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_tvalid,
	output logic             s_tready,
	input  wire logic [39:0] s_tdata,   // [31:0] data_word, [33:32] access_size
	input  wire logic        s_tuser,   // [0] func
	output logic             m_tvalid,
	input  wire logic        m_tready,
	output logic      [31:0] m_tdata,   // [31:0] crc_value
	input  wire logic        psel,
	input  wire logic        penable,
	input  wire logic        pwrite,
	input  wire logic [4:0]  paddr,
	input  wire logic [31:0] pwdata,
	output logic      [31:0] prdata,
	output logic             pready
);
	import pcrc_pkg::*;

	pcrc_cfg_t cfg;

	pcrc_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	pcrc_core u_core (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg),
		.in_valid  (s_tvalid),
		.in_ready  (s_tready),
		.in_func   (s_tuser),
		.in_data   (s_tdata[31:0]),
		.in_size   (s_tdata[33:32]),
		.out_valid (m_tvalid),
		.out_ready (m_tready),
		.out_crc   (m_tdata)
	);

endmodule : programmable_crc_unit
`default_nettype wire

// ===== hw/rtl/pcrc_checker.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// pcrc_checker
// Port-level checks for the programmable CRC unit, bound to the top level.
// ----------------------------------------------------------------------------
module pcrc_checker (
	input wire logic        clk,
	input wire logic        arst_n,
	input wire logic        s_tvalid,
	input wire logic        s_tready,
	input wire logic        s_tuser,
	input wire logic        m_tvalid,
	input wire logic        m_tready,
	input wire logic [31:0] m_tdata
);
	import pcrc_pkg::*;

	// a result beat holds until taken
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata)))
		else $error("result beat dropped or changed while stalled");

	// engine is busy after every accepted beat
	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(s_tvalid && s_tready) |=> !s_tready)
		else $error("input accepted while engine busy");

	// a restart accepted while the output is empty reaches the output
	a_restart_lat: assert property (@(posedge clk) disable iff (!arst_n)
		(s_tvalid && s_tready && (s_tuser == FUNC_RESTART) && !m_tvalid)
		|-> ##2 m_tvalid)
		else $error("restart result late");

	// a new result only comes out of a busy engine
	a_no_spurious: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_tvalid) |-> $past(!s_tready))
		else $error("result without an item in flight");

endmodule : pcrc_checker

bind programmable_crc_unit pcrc_checker u_pcrc_checker (.*);
`default_nettype wire
